// ----- design/rjt_pkg.sv -----
// Package for the range jump table block.
// Holds field widths, status and command codes, and the control/status
// structs passed between the controller and the datapath. No dependencies.
`default_nettype none

package rjt_pkg;

    // Fixed port field widths.
    localparam int RV_BITS  = 16;
    localparam int QI_BITS  = 10;
    localparam int IDX_BITS = 11;
    localparam int ST_BITS  = 2;

    // Input command codes.
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Result status codes.
    localparam logic [ST_BITS-1:0] STATUS_OK   = 2'd0;
    localparam logic [ST_BITS-1:0] STATUS_OOB  = 2'd1;
    localparam logic [ST_BITS-1:0] STATUS_FULL = 2'd2;

    // Reported when an earlier search finds nothing (-1 in 11 bits).
    localparam logic [IDX_BITS-1:0] NONE_EARLIER = '1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // store one sample unless full and post its result word
        logic res_bad;    // post an out-of-range query result word
        logic q_begin;    // latch the query index and read its range
        logic q_here;     // capture the reference range, start forward scan
        logic step_fwd;   // one forward scan step
        logic bwd_begin;  // set up the backward scan
        logic step_bwd;   // one backward scan step
        logic res_query;  // post the finished query result word
    } rjt_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic oob;        // query index at or beyond the point count
        logic fwd_done;   // forward scan has nothing left to do
        logic bwd_done;   // backward scan has nothing left to do
    } rjt_stat_t;

endpackage

`default_nettype wire

// ----- design/rjt_dp.sv -----
// Datapath of the range jump table: range memory, point count, scan
// pointer, compare logic and the result word registers.
// Depends on rjt_pkg; driven by commands from rjt_ctrl.
`default_nettype none

module rjt_dp #(
    parameter int MAX_POINTS = 1024,
    parameter int RANGE_BITS = 16
) (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  rjt_pkg::rjt_cmd_t                     cmd,
    output rjt_pkg::rjt_stat_t                    stat,
    input  wire  [rjt_pkg::RV_BITS-1:0]           range_value,
    input  wire                                   first_of_scan,
    input  wire  [rjt_pkg::QI_BITS-1:0]           query_index,
    output logic                                  strobe,
    output logic [rjt_pkg::ST_BITS-1:0]           status,
    output logic [rjt_pkg::IDX_BITS-1:0]          point_count,
    output logic [rjt_pkg::IDX_BITS-1:0]          later_smaller,
    output logic [rjt_pkg::IDX_BITS-1:0]          later_larger,
    output logic signed [rjt_pkg::IDX_BITS-1:0]   earlier_smaller,
    output logic signed [rjt_pkg::IDX_BITS-1:0]   earlier_larger
);
    import rjt_pkg::*;

    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int AW = $clog2(MAX_POINTS);
    localparam int QW = (CW > QI_BITS) ? CW : QI_BITS;

    // Range memory, no reset: only entries below the count are ever read.
    logic [RANGE_BITS-1:0] mem [MAX_POINTS];

    logic [CW-1:0]         count_reg;
    logic [CW-1:0]         count_next;
    logic [CW-1:0]         qi_reg;
    logic [CW-1:0]         ptr_reg;
    logic [CW-1:0]         pend_idx_reg;
    logic                  live_reg;
    logic                  live_next;
    logic                  pend_reg;
    logic                  pend_next;
    logic [RANGE_BITS-1:0] rd_data_reg;
    logic [RANGE_BITS-1:0] here_reg;
    logic [CW-1:0]         fs_reg;
    logic [CW-1:0]         fl_reg;
    logic [CW-1:0]         bs_reg;
    logic [CW-1:0]         bl_reg;
    logic                  fs_hit_reg;
    logic                  fl_hit_reg;
    logic                  bs_hit_reg;
    logic                  bl_hit_reg;
    logic                  valid_reg;
    logic [ST_BITS-1:0]    status_reg;
    logic [IDX_BITS-1:0]   pc_reg;
    logic [IDX_BITS-1:0]   ls_reg;
    logic [IDX_BITS-1:0]   ll_reg;
    logic [IDX_BITS-1:0]   es_reg;
    logic [IDX_BITS-1:0]   el_reg;

    logic [QW-1:0]         qi_ext;
    logic [QW-1:0]         cnt_ext;
    logic [CW-1:0]         load_base;
    logic                  full;
    logic [RANGE_BITS-1:0] rv_kept;
    logic [AW-1:0]         rd_addr;
    logic                  rd_en;
    logic                  lt;
    logic                  gt;
    logic                  fwd_cmp;
    logic                  bwd_cmp;

    // Input decode for loads and the range check for queries.
    assign qi_ext    = QW'(query_index);
    assign cnt_ext   = QW'(count_reg);
    assign load_base = first_of_scan ? '0 : count_reg;
    assign full      = (load_base == CW'(MAX_POINTS));
    assign rv_kept   = RANGE_BITS'(range_value);

    // Scan status for the controller.
    assign stat.oob      = (qi_ext >= cnt_ext);
    assign stat.fwd_done = (!live_reg && !pend_reg) || (fs_hit_reg && fl_hit_reg);
    assign stat.bwd_done = (!live_reg && !pend_reg) || (bs_hit_reg && bl_hit_reg);

    // Memory write port.
    always_ff @(posedge clk)
    begin
        if (cmd.load && !full)
        begin
            mem[load_base[AW-1:0]] <= rv_kept;
        end
    end

    // Memory read port with registered data.
    assign rd_addr = cmd.q_begin ? qi_ext[AW-1:0] : ptr_reg[AW-1:0];
    assign rd_en   = cmd.q_begin || ((cmd.step_fwd || cmd.step_bwd) && live_reg);

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Compare the word read last cycle against the reference range.
    assign lt      = (rd_data_reg < here_reg);
    assign gt      = (rd_data_reg > here_reg);
    assign fwd_cmp = cmd.step_fwd && pend_reg;
    assign bwd_cmp = cmd.step_bwd && pend_reg;

    // Next values of the point count and the scan issue flags.
    always_comb
    begin
        count_next = count_reg;
        live_next  = live_reg;
        pend_next  = pend_reg;
        if (cmd.load && !full)
        begin
            count_next = CW'(load_base + 1'b1);
        end
        if (cmd.q_begin || cmd.bwd_begin)
        begin
            pend_next = 1'b0;
            live_next = cmd.bwd_begin ? (qi_reg != '0) : 1'b0;
        end
        else if (cmd.q_here)
        begin
            pend_next = 1'b0;
            live_next = (ptr_reg < count_reg);
        end
        else if (cmd.step_fwd || cmd.step_bwd)
        begin
            pend_next = live_reg;
            if (live_reg)
            begin
                live_next = cmd.step_fwd ? (CW'(ptr_reg + 1'b1) < count_reg)
                                         : (ptr_reg != '0);
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            live_reg   <= 1'b0;
            pend_reg   <= 1'b0;
            valid_reg  <= 1'b0;
            fs_hit_reg <= 1'b0;
            fl_hit_reg <= 1'b0;
            bs_hit_reg <= 1'b0;
            bl_hit_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            live_reg  <= live_next;
            pend_reg  <= pend_next;
            valid_reg <= cmd.load || cmd.res_bad || cmd.res_query;
            if (cmd.q_begin)
            begin
                fs_hit_reg <= 1'b0;
                fl_hit_reg <= 1'b0;
                bs_hit_reg <= 1'b0;
                bl_hit_reg <= 1'b0;
            end
            else
            begin
                if (fwd_cmp && lt)
                begin
                    fs_hit_reg <= 1'b1;
                end
                if (fwd_cmp && gt)
                begin
                    fl_hit_reg <= 1'b1;
                end
                if (bwd_cmp && lt)
                begin
                    bs_hit_reg <= 1'b1;
                end
                if (bwd_cmp && gt)
                begin
                    bl_hit_reg <= 1'b1;
                end
            end
        end
    end

    // Scan pointer, reference range and the nearest hit indices.
    always_ff @(posedge clk)
    begin
        if (cmd.q_begin)
        begin
            qi_reg  <= qi_ext[CW-1:0];
            ptr_reg <= CW'(qi_ext[CW-1:0] + 1'b1);
        end
        else if (cmd.bwd_begin)
        begin
            ptr_reg <= CW'(qi_reg - 1'b1);
        end
        else if (cmd.step_fwd && live_reg)
        begin
            ptr_reg      <= CW'(ptr_reg + 1'b1);
            pend_idx_reg <= ptr_reg;
        end
        else if (cmd.step_bwd && live_reg)
        begin
            ptr_reg      <= CW'(ptr_reg - 1'b1);
            pend_idx_reg <= ptr_reg;
        end
        if (cmd.q_here)
        begin
            here_reg <= rd_data_reg;
        end
        if (fwd_cmp && lt && !fs_hit_reg)
        begin
            fs_reg <= pend_idx_reg;
        end
        if (fwd_cmp && gt && !fl_hit_reg)
        begin
            fl_reg <= pend_idx_reg;
        end
        if (bwd_cmp && lt && !bs_hit_reg)
        begin
            bs_reg <= pend_idx_reg;
        end
        if (bwd_cmp && gt && !bl_hit_reg)
        begin
            bl_reg <= pend_idx_reg;
        end
    end

    // Result word registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            status_reg <= full ? STATUS_FULL : STATUS_OK;
            pc_reg     <= IDX_BITS'(count_next);
            ls_reg     <= '0;
            ll_reg     <= '0;
            es_reg     <= '0;
            el_reg     <= '0;
        end
        else if (cmd.res_bad)
        begin
            status_reg <= STATUS_OOB;
            pc_reg     <= IDX_BITS'(count_reg);
            ls_reg     <= '0;
            ll_reg     <= '0;
            es_reg     <= '0;
            el_reg     <= '0;
        end
        else if (cmd.res_query)
        begin
            status_reg <= STATUS_OK;
            pc_reg     <= IDX_BITS'(count_reg);
            ls_reg     <= fs_hit_reg ? IDX_BITS'(fs_reg) : IDX_BITS'(count_reg);
            ll_reg     <= fl_hit_reg ? IDX_BITS'(fl_reg) : IDX_BITS'(count_reg);
            es_reg     <= bs_hit_reg ? IDX_BITS'(bs_reg) : NONE_EARLIER;
            el_reg     <= bl_hit_reg ? IDX_BITS'(bl_reg) : NONE_EARLIER;
        end
    end

    assign strobe          = valid_reg;
    assign status          = status_reg;
    assign point_count     = pc_reg;
    assign later_smaller   = ls_reg;
    assign later_larger    = ll_reg;
    assign earlier_smaller = $signed(es_reg);
    assign earlier_larger  = $signed(el_reg);

`ifndef SYNTHESIS
    // The point count never passes the memory depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_POINTS))
        else $error("point count beyond memory depth");

    // A forward hit, once found, is kept for the rest of the scan.
    a_fs_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step_fwd && fs_hit_reg) |=> (fs_hit_reg && $stable(fs_reg)))
        else $error("forward smaller hit overwritten");

    // A compare becomes pending only after a scan step that issued a read.
    a_pend_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(pend_reg) |-> $past(live_reg))
        else $error("pending compare without an issued read");
`endif

endmodule

`default_nettype wire

// ----- design/rjt_ctrl.sv -----
// Controller of the range jump table: sequences loads, the reference read
// and the forward and backward scans of a query. Depends on rjt_pkg;
// commands rjt_dp and reads its status.
`default_nettype none

module rjt_ctrl (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 start,
    input  wire                 command,
    input  rjt_pkg::rjt_stat_t  stat,
    output rjt_pkg::rjt_cmd_t   cmd,
    output logic                busy
);
    import rjt_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HERE,
        ST_FWD,
        ST_BWD
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;

    // Command decode and next state.
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (command == CMD_LOAD)
                    begin
                        cmd.load = 1'b1;
                    end
                    else if (stat.oob)
                    begin
                        cmd.res_bad = 1'b1;
                    end
                    else
                    begin
                        cmd.q_begin = 1'b1;
                        state_next  = ST_HERE;
                    end
                end
            end
            ST_HERE:
            begin
                cmd.q_here = 1'b1;
                state_next = ST_FWD;
            end
            ST_FWD:
            begin
                if (stat.fwd_done)
                begin
                    cmd.bwd_begin = 1'b1;
                    state_next    = ST_BWD;
                end
                else
                begin
                    cmd.step_fwd = 1'b1;
                end
            end
            ST_BWD:
            begin
                if (stat.bwd_done)
                begin
                    cmd.res_query = 1'b1;
                    state_next    = ST_IDLE;
                end
                else
                begin
                    cmd.step_bwd = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered busy flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= (state_next != ST_IDLE);
        end
    end

    assign busy = busy_reg;

`ifndef SYNTHESIS
    // At most one datapath command is issued in any cycle.
    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cmd))
        else $error("several datapath commands at once");

    // An in-range query makes the block busy on the next cycle.
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && command == CMD_QUERY && !stat.oob) |=> busy)
        else $error("query accepted but block not busy");

    // A finished forward scan hands over to the backward scan.
    a_fwd_to_bwd: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FWD && stat.fwd_done) |=> (state_reg == ST_BWD))
        else $error("forward scan did not hand over");
`endif

endmodule

`default_nettype wire

// ----- design/range_jump_table.sv -----
// Range jump table: one laser scan of ranges, loaded a sample at a time,
// with nearest smaller/larger index queries in both directions.
// Loads and out-of-range queries: result strobe in the cycle after start, one word a cycle
// while not busy. In-range query: strobe after the reference read and both scans, one
// memory read per scanned point; busy drops in the strobe cycle; results never stall.
// Reset clears the point count and control; memory contents are kept.
`default_nettype none

module range_jump_table #(
    parameter int MAX_POINTS = 1024,
    parameter int RANGE_BITS = 16
) (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire                                   start,
    output logic                                  busy,
    input  wire                                   command,
    input  wire  [rjt_pkg::RV_BITS-1:0]           range_value,
    input  wire                                   first_of_scan,
    input  wire  [rjt_pkg::QI_BITS-1:0]           query_index,
    output logic                                  strobe,
    output logic [rjt_pkg::ST_BITS-1:0]           status,
    output logic [rjt_pkg::IDX_BITS-1:0]          point_count,
    output logic [rjt_pkg::IDX_BITS-1:0]          later_smaller,
    output logic [rjt_pkg::IDX_BITS-1:0]          later_larger,
    output logic signed [rjt_pkg::IDX_BITS-1:0]   earlier_smaller,
    output logic signed [rjt_pkg::IDX_BITS-1:0]   earlier_larger
);
    import rjt_pkg::*;

    rjt_cmd_t  cmd;
    rjt_stat_t stat;
    logic      go;

    // Only accepted words reach the controller.
    assign go = start && !busy;

    rjt_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (go),
        .command (command),
        .stat    (stat),
        .cmd     (cmd),
        .busy    (busy)
    );

    rjt_dp #(
        .MAX_POINTS (MAX_POINTS),
        .RANGE_BITS (RANGE_BITS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .range_value     (range_value),
        .first_of_scan   (first_of_scan),
        .query_index     (query_index),
        .strobe          (strobe),
        .status          (status),
        .point_count     (point_count),
        .later_smaller   (later_smaller),
        .later_larger    (later_larger),
        .earlier_smaller (earlier_smaller),
        .earlier_larger  (earlier_larger)
    );

endmodule

`default_nettype wire
